>>> hw/rtl/lcd_mode_sequencer_defines.svh
// ---------------------------------------------------------------------------
// LCD mode sequencer assertion macros
// Clocked on clk, disabled while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef LCD_MODE_SEQUENCER_DEFINES_SVH
`define LCD_MODE_SEQUENCER_DEFINES_SVH

`ifndef NO_ASSERTIONS
// Check that a condition holds at every clock edge
`define LCDMS_ASSERT(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// Check that the consequent holds whenever the antecedent holds
`define LCDMS_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define LCDMS_ASSERT(lbl, cond, msg)
`define LCDMS_IMPLY(lbl, ante, cons, msg)
`endif

`endif

>>> hw/rtl/lcdms_pkg.sv
// ---------------------------------------------------------------------------
// lcdms_pkg
// Widths, phase and mode codes, register indexes and shared types of the
// LCD mode sequencer.
// ---------------------------------------------------------------------------
package lcdms_pkg;

  localparam int LCDMS_CYC_W      = 6;
  localparam int LCDMS_DOT_W      = 10;
  localparam int LCDMS_LINE_W     = 8;
  localparam int LCDMS_CFG_IDX_W  = 2;
  localparam int LCDMS_CFG_DATA_W = 8;

  // Default phase lengths in machine cycles
  localparam int unsigned LCDMS_OAM_CLOCKS      = 80;
  localparam int unsigned LCDMS_TRANSFER_CLOCKS = 172;
  localparam int unsigned LCDMS_HBLANK_CLOCKS   = 204;
  localparam int unsigned LCDMS_LINE_CLOCKS     = 456;

  // Internal phase codes
  localparam logic [1:0] PH_OAM    = 2'd0;
  localparam logic [1:0] PH_XFER   = 2'd1;
  localparam logic [1:0] PH_HBLANK = 2'd2;
  localparam logic [1:0] PH_VBLANK = 2'd3;

  // Status mode codes
  localparam logic [1:0] MODE_HBLANK = 2'd0;
  localparam logic [1:0] MODE_VBLANK = 2'd1;
  localparam logic [1:0] MODE_OAM    = 2'd2;
  localparam logic [1:0] MODE_XFER   = 2'd3;

  // Line numbers
  localparam logic [LCDMS_LINE_W-1:0] VBLANK_LINE = 8'd144;
  localparam logic [LCDMS_LINE_W-1:0] LAST_LINE   = 8'd154;

  // Configuration register indexes
  localparam logic [LCDMS_CFG_IDX_W-1:0] REG_HBLANK_EN = 2'd0;
  localparam logic [LCDMS_CFG_IDX_W-1:0] REG_MATCH_EN  = 2'd1;
  localparam logic [LCDMS_CFG_IDX_W-1:0] REG_LINE_CMP  = 2'd2;

  typedef struct packed {
    logic [1:0]              phase;
    logic [LCDMS_DOT_W-1:0]  dot_count;
    logic [LCDMS_LINE_W-1:0] line_count;
    logic [1:0]              mode_bits;
    logic                    match_flag;
  } lcdms_state_t;

  typedef struct packed {
    logic                    hblank_irq_enable;
    logic                    match_irq_enable;
    logic [LCDMS_LINE_W-1:0] line_compare;
  } lcdms_cfg_t;

  typedef struct packed {
    logic stat_irq;
    logic vblank_irq;
    logic line_done;
    logic frame_done;
  } lcdms_flags_t;

endpackage

>>> hw/rtl/lcdms_step.sv
// ---------------------------------------------------------------------------
// lcdms_step
// One tick of the phase sequencer: add the elapsed cycles, compare with the
// current phase length, and make at most one phase change.
// ---------------------------------------------------------------------------
module lcdms_step
  import lcdms_pkg::*;
#(
  parameter int unsigned OAM_CLOCKS      = LCDMS_OAM_CLOCKS,
  parameter int unsigned TRANSFER_CLOCKS = LCDMS_TRANSFER_CLOCKS,
  parameter int unsigned HBLANK_CLOCKS   = LCDMS_HBLANK_CLOCKS,
  parameter int unsigned LINE_CLOCKS     = LCDMS_LINE_CLOCKS
) (
  input  lcdms_state_t           cur,
  input  lcdms_cfg_t             cfg,
  input  logic [LCDMS_CYC_W-1:0] cycles,
  output lcdms_state_t           nxt,
  output lcdms_flags_t           flags
);

  localparam logic [LCDMS_DOT_W-1:0] OAM_LEN    = LCDMS_DOT_W'(OAM_CLOCKS);
  localparam logic [LCDMS_DOT_W-1:0] XFER_LEN   = LCDMS_DOT_W'(TRANSFER_CLOCKS);
  localparam logic [LCDMS_DOT_W-1:0] HBLANK_LEN = LCDMS_DOT_W'(HBLANK_CLOCKS);
  localparam logic [LCDMS_DOT_W-1:0] LINE_LEN   = LCDMS_DOT_W'(LINE_CLOCKS);

  logic [LCDMS_DOT_W-1:0]  len;
  logic [LCDMS_DOT_W-1:0]  sum;
  logic [LCDMS_LINE_W-1:0] line_inc;
  logic                    match;

  // Select the length of the current phase
  always_comb begin
    case (cur.phase)
      PH_OAM:    len = OAM_LEN;
      PH_XFER:   len = XFER_LEN;
      PH_HBLANK: len = HBLANK_LEN;
      default:   len = LINE_LEN;
    endcase
  end

  assign sum      = cur.dot_count + LCDMS_DOT_W'(cycles);
  assign line_inc = cur.line_count + 1'b1;
  assign match    = (cur.line_count == cfg.line_compare);

  // Advance the phase (in vblank, the line) when the counter reaches its length
  always_comb begin
    nxt       = cur;
    nxt.dot_count = sum;
    flags     = '0;
    if (sum >= len) begin
      nxt.dot_count = sum - len;
      case (cur.phase)
        PH_OAM: begin
          nxt.phase     = PH_XFER;
          nxt.mode_bits = MODE_XFER;
        end
        PH_XFER: begin
          nxt.phase      = PH_HBLANK;
          nxt.mode_bits  = MODE_HBLANK;
          nxt.match_flag = match;
          flags.stat_irq = cfg.hblank_irq_enable | (cfg.match_irq_enable & match);
        end
        PH_HBLANK: begin
          flags.line_done = 1'b1;
          nxt.line_count  = line_inc;
          if (line_inc == VBLANK_LINE) begin
            nxt.phase        = PH_VBLANK;
            nxt.mode_bits    = MODE_VBLANK;
            flags.vblank_irq = 1'b1;
          end else begin
            nxt.phase     = PH_OAM;
            nxt.mode_bits = MODE_OAM;
          end
        end
        default: begin
          nxt.line_count = line_inc;
          if (line_inc == LAST_LINE) begin
            flags.frame_done = 1'b1;
            nxt.line_count   = '0;
            nxt.phase        = PH_OAM;
            nxt.mode_bits    = MODE_OAM;
          end
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/lcd_mode_sequencer.sv
// ---------------------------------------------------------------------------
// lcd_mode_sequencer
// Display phase timing: OAM search, pixel transfer, hblank and vblank, with
// line counting, STAT and vblank requests. One result per tick.
// ---------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | in_cycles_elapsed
//  out_    | output    | out_valid / out_ready | mode, line, flags
//  cfg_    | input     | cfg_we                | cfg_index, cfg_wdata
//
//  Each tick is registered, then stepped into the result register; one
//  tick per cycle sustained while out_ready holds, bound by the
//  single add, compare and subtract on the dot counter.
//  Reset (synchronous, rst_n low) puts the sequencer in OAM search, line 0.
//  A stalled result holds its stage; the input stage keeps taking ticks
//  until both stages are full.
// ---------------------------------------------------------------------------
`include "lcd_mode_sequencer_defines.svh"

module lcd_mode_sequencer
  import lcdms_pkg::*;
#(
  parameter int unsigned OAM_CLOCKS      = LCDMS_OAM_CLOCKS,
  parameter int unsigned TRANSFER_CLOCKS = LCDMS_TRANSFER_CLOCKS,
  parameter int unsigned HBLANK_CLOCKS   = LCDMS_HBLANK_CLOCKS,
  parameter int unsigned LINE_CLOCKS     = LCDMS_LINE_CLOCKS
) (
  input  logic                        clk,
  input  logic                        rst_n,
  // configuration
  input  logic                        cfg_we,
  input  logic [LCDMS_CFG_IDX_W-1:0]  cfg_index,
  input  logic [LCDMS_CFG_DATA_W-1:0] cfg_wdata,
  // ticks
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [LCDMS_CYC_W-1:0]      in_cycles_elapsed,
  // results
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [1:0]                  out_mode,
  output logic [LCDMS_LINE_W-1:0]     out_current_line,
  output logic                        out_coincidence,
  output logic                        out_stat_irq,
  output logic                        out_vblank_irq,
  output logic                        out_line_done,
  output logic                        out_frame_done
);

  lcdms_cfg_t                 cfg_r;
  lcdms_state_t               state_r;
  lcdms_state_t               state_nxt;
  lcdms_flags_t               flags_nxt;
  lcdms_flags_t               out_flags_r;
  logic                       in_valid_r;
  logic [LCDMS_CYC_W-1:0]     in_cycles_r;
  logic                       out_valid_r;
  logic [1:0]                 out_mode_r;
  logic [LCDMS_LINE_W-1:0]    out_line_r;
  logic                       out_match_r;
  logic                       step_go;

  // Write configuration registers; ignore unused indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HBLANK_EN: cfg_r.hblank_irq_enable <= cfg_wdata[0];
        REG_MATCH_EN:  cfg_r.match_irq_enable  <= cfg_wdata[0];
        REG_LINE_CMP:  cfg_r.line_compare      <= cfg_wdata;
        default:       ;
      endcase
    end
  end

  // Advance a tick when the result register is free or being emptied
  assign step_go  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || step_go;

  // Hold the incoming tick
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_ready) begin
      in_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_cycles_r <= in_cycles_elapsed;
    end
  end

  lcdms_step #(
    .OAM_CLOCKS      (OAM_CLOCKS),
    .TRANSFER_CLOCKS (TRANSFER_CLOCKS),
    .HBLANK_CLOCKS   (HBLANK_CLOCKS),
    .LINE_CLOCKS     (LINE_CLOCKS)
  ) u_step (
    .cur    (state_r),
    .cfg    (cfg_r),
    .cycles (in_cycles_r),
    .nxt    (state_nxt),
    .flags  (flags_nxt)
  );

  // Update sequencer state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= '{phase: PH_OAM, dot_count: '0, line_count: '0,
                   mode_bits: MODE_HBLANK, match_flag: 1'b0};
    end else if (step_go) begin
      state_r <= state_nxt;
    end
  end

  // Track the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (step_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step_go) begin
      out_mode_r  <= state_nxt.mode_bits;
      out_line_r  <= state_nxt.line_count;
      out_match_r <= state_nxt.match_flag;
      out_flags_r <= flags_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_mode         = out_mode_r;
  assign out_current_line = out_line_r;
  assign out_coincidence  = out_match_r;
  assign out_stat_irq     = out_flags_r.stat_irq;
  assign out_vblank_irq   = out_flags_r.vblank_irq;
  assign out_line_done    = out_flags_r.line_done;
  assign out_frame_done   = out_flags_r.frame_done;

  // Line stays in the frame; vblank only on its lines; STAT at hblank start; frame end wraps
  `LCDMS_ASSERT(a_line_range, state_r.line_count < LAST_LINE, "line count out of frame")
  `LCDMS_IMPLY(a_vblank_line, state_r.phase == PH_VBLANK, state_r.line_count >= VBLANK_LINE, "vblank phase on a visible line")
  `LCDMS_IMPLY(a_stat_mode, out_valid_r && out_flags_r.stat_irq, out_mode_r == MODE_HBLANK, "stat request outside hblank start")
  `LCDMS_IMPLY(a_frame_line, out_valid_r && out_flags_r.frame_done, out_line_r == '0 && out_mode_r == MODE_OAM, "frame end without wrap")

endmodule

>>> sim/lcd_mode_sequencer_tb.sv
// ---------------------------------------------------------------------------
// lcd_mode_sequencer_tb
// Drives tick items into the LCD mode sequencer and checks every result
// against a tick-level prediction of the phase, line and request logic.
// Directed ticks cover reset mode, exact phase boundaries and both STAT
// sources; random ticks sweep a whole frame, line compare settings and
// back-pressure on both channels.
// ---------------------------------------------------------------------------
module lcd_mode_sequencer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lcdms_pkg::*;

  localparam int SETTLE_CYCLES = 4;      // pipeline is two stages deep
  localparam int HOLD_CYCLES   = 64;     // long receiver hold-off
  localparam int STUCK_LIMIT   = 1000;   // cycles with no item moving
  localparam int MAX_REPORTS   = 10;

  // Index past the end of the register map, must be ignored
  localparam logic [LCDMS_CFG_IDX_W-1:0] REG_SPARE = 2'd3;

  localparam logic [LCDMS_DOT_W-1:0] OAM_LEN    = LCDMS_DOT_W'(LCDMS_OAM_CLOCKS);
  localparam logic [LCDMS_DOT_W-1:0] XFER_LEN   = LCDMS_DOT_W'(LCDMS_TRANSFER_CLOCKS);
  localparam logic [LCDMS_DOT_W-1:0] HBLANK_LEN = LCDMS_DOT_W'(LCDMS_HBLANK_CLOCKS);
  localparam logic [LCDMS_DOT_W-1:0] LINE_LEN   = LCDMS_DOT_W'(LCDMS_LINE_CLOCKS);

  typedef struct packed {
    logic [1:0]              mode;
    logic [LCDMS_LINE_W-1:0] line;
    logic                    coincidence;
    logic                    stat_irq;
    logic                    vblank_irq;
    logic                    line_done;
    logic                    frame_done;
  } line_status_t;

  logic                        clk = 1'b0;
  logic                        rst_n = 1'b0;
  logic                        cfg_we = 1'b0;
  logic [LCDMS_CFG_IDX_W-1:0]  cfg_index = '0;
  logic [LCDMS_CFG_DATA_W-1:0] cfg_wdata = '0;
  logic                        in_valid = 1'b0;
  logic                        in_ready;
  logic [LCDMS_CYC_W-1:0]      in_cycles_elapsed = '0;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic [1:0]                  out_mode;
  logic [LCDMS_LINE_W-1:0]     out_current_line;
  logic                        out_coincidence;
  logic                        out_stat_irq;
  logic                        out_vblank_irq;
  logic                        out_line_done;
  logic                        out_frame_done;

  // Predicted sequencer state and register copies
  logic [1:0]              seq_phase = PH_OAM;
  logic [LCDMS_DOT_W-1:0]  seq_dots = '0;
  logic [LCDMS_LINE_W-1:0] seq_line = '0;
  logic [1:0]              seq_mode = MODE_HBLANK;
  logic                    seq_match = 1'b0;
  logic                    en_hblank_stat = 1'b0;
  logic                    en_match_stat = 1'b0;
  logic [LCDMS_LINE_W-1:0] cmp_line = '0;
  int                      frames_seen = 0;

  line_status_t pending_status_q[$];
  int           fail_count = 0;
  int           stuck_cycles = 0;
  int           stall_left = 0;
  logic         tx_idle = 1'b1;
  logic         rx_idle = 1'b1;
  logic         hold_req = 1'b0;

  lcd_mode_sequencer uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cycles_elapsed (in_cycles_elapsed),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_mode          (out_mode),
    .out_current_line  (out_current_line),
    .out_coincidence   (out_coincidence),
    .out_stat_irq      (out_stat_irq),
    .out_vblank_irq    (out_vblank_irq),
    .out_line_done     (out_line_done),
    .out_frame_done    (out_frame_done)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------
  function automatic logic [LCDMS_DOT_W-1:0] phase_clocks(logic [1:0] ph);
    case (ph)
      PH_OAM:    return OAM_LEN;
      PH_XFER:   return XFER_LEN;
      PH_HBLANK: return HBLANK_LEN;
      default:   return LINE_LEN;
    endcase
  endfunction

  // Advance the predicted sequencer by one tick and queue its status
  function automatic void advance_sequencer(logic [LCDMS_CYC_W-1:0] cyc);
    line_status_t           r;
    logic [LCDMS_DOT_W-1:0] len;
    r = '0;
    len = phase_clocks(seq_phase);
    seq_dots = seq_dots + cyc;
    if (seq_dots >= len) begin
      seq_dots = seq_dots - len;
      case (seq_phase)
        PH_OAM: begin
          seq_phase = PH_XFER;
          seq_mode = MODE_XFER;
        end
        PH_XFER: begin
          // coincidence refreshes only at the end of transfer
          seq_match = (seq_line == cmp_line);
          r.stat_irq = en_hblank_stat | (en_match_stat & seq_match);
          seq_phase = PH_HBLANK;
          seq_mode = MODE_HBLANK;
        end
        PH_HBLANK: begin
          r.line_done = 1'b1;
          seq_line = seq_line + 1'b1;
          if (seq_line == VBLANK_LINE) begin
            seq_phase = PH_VBLANK;
            seq_mode = MODE_VBLANK;
            r.vblank_irq = 1'b1;
          end else begin
            seq_phase = PH_OAM;
            seq_mode = MODE_OAM;
          end
        end
        default: begin
          seq_line = seq_line + 1'b1;
          if (seq_line == LAST_LINE) begin
            r.frame_done = 1'b1;
            seq_line = '0;
            seq_phase = PH_OAM;
            seq_mode = MODE_OAM;
            frames_seen++;
          end
        end
      endcase
    end
    r.mode = seq_mode;
    r.line = seq_line;
    r.coincidence = seq_match;
    pending_status_q.push_back(r);
  endfunction

  function automatic string status_text(line_status_t s);
    return $sformatf("mode=%0d line=%0d coin=%0b stat=%0b vbl=%0b ldone=%0b fdone=%0b",
                     s.mode, s.line, s.coincidence, s.stat_irq, s.vblank_irq,
                     s.line_done, s.frame_done);
  endfunction

  // ---------------------------------------------------------------------
  // Result receiver: random stalls, plus one long hold-off on request
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_left = 0;
    end else if (hold_req) begin
      out_ready <= 1'b0;
      stall_left = HOLD_CYCLES;
    end else if (out_valid && out_ready) begin
      stall_left = rx_idle ? $urandom_range(0, 11) : 0;
      out_ready <= (stall_left == 0);
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= (stall_left == 0);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare each accepted result with the oldest prediction
  always @(posedge clk) begin : check_results
    line_status_t got;
    line_status_t want;
    if (rst_n && out_valid && out_ready) begin
      got = '{out_mode, out_current_line, out_coincidence, out_stat_irq,
              out_vblank_irq, out_line_done, out_frame_done};
      if (pending_status_q.size() == 0) begin
        fail_count++;
        if (fail_count <= MAX_REPORTS)
          $display("ERROR: result with no tick pending: %s", status_text(got));
      end else begin
        want = pending_status_q.pop_front();
        if (got !== want) begin
          fail_count++;
          if (fail_count <= MAX_REPORTS)
            $display("ERROR: expected %s, actual %s", status_text(want), status_text(got));
        end
      end
    end
  end

  // Abort when no item moves on either channel for too long
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
      stuck_cycles <= 0;
    end else if (stuck_cycles >= STUCK_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------
  // Offer one tick, after a random gap while tx_idle is set, hold until accepted
  task automatic send_tick(input logic [LCDMS_CYC_W-1:0] cyc);
    int gap;
    gap = tx_idle ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_cycles_elapsed <= cyc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    advance_sequencer(cyc);
  endtask

  // Stop offering and wait for every predicted result
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_status_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [LCDMS_CFG_IDX_W-1:0] idx,
                           input logic [LCDMS_CFG_DATA_W-1:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_HBLANK_EN: en_hblank_stat = data[0];
      REG_MATCH_EN:  en_match_stat = data[0];
      REG_LINE_CMP:  cmp_line = data;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Write all three registers; upper bits of the enables are junk
  task automatic set_config(input logic hb, input logic me,
                            input logic [LCDMS_LINE_W-1:0] cmp);
    write_reg(REG_HBLANK_EN, {7'($urandom_range(0, 127)), hb});
    write_reg(REG_MATCH_EN, {7'($urandom_range(0, 127)), me});
    write_reg(REG_LINE_CMP, cmp);
  endtask

  // Mostly uniform ticks, with some tiny and some maximal ones
  function automatic logic [LCDMS_CYC_W-1:0] draw_tick();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 6) return LCDMS_CYC_W'($urandom_range(0, 63));
    else if (sel < 8) return LCDMS_CYC_W'($urandom_range(0, 3));
    else return '1;
  endfunction

  // Compare value: zero, all ones, random, or near the current line so matches come soon
  function automatic logic [LCDMS_LINE_W-1:0] draw_compare();
    case ($urandom_range(0, 3))
      0:       return '0;
      1:       return '1;
      2:       return seq_line + LCDMS_LINE_W'($urandom_range(0, 2));
      default: return LCDMS_LINE_W'($urandom_range(0, 255));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------
  // Reset mode, exact boundaries, both STAT sources, ignored index
  task automatic test_directed();
    logic [LCDMS_CYC_W-1:0] match_ticks [15];
    logic [LCDMS_CYC_W-1:0] hblank_ticks [8];
    match_ticks = '{6'd0, 6'd0, 6'd63, 6'd17, 6'd63, 6'd63, 6'd45, 6'd1,
                    6'd63, 6'd63, 6'd63, 6'd15, 6'd63, 6'd16, 6'd1};
    hblank_ticks = '{6'd63, 6'd63, 6'd46, 6'd63, 6'd63, 6'd63, 6'd63, 6'd32};
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    set_config(1'b0, 1'b1, 8'd0);
    write_reg(REG_SPARE, 8'hFF);
    foreach (match_ticks[i]) send_tick(match_ticks[i]);
    drain_results();
    set_config(1'b1, 1'b0, 8'hFF);
    write_reg(REG_SPARE, 8'h00);
    foreach (hblank_ticks[i]) send_tick(hblank_ticks[i]);
  endtask

  // Enable combinations against compare values around the current line
  task automatic test_line_compare();
    for (int round = 0; round < 6; round++) begin
      drain_results();
      case (round)
        0:       set_config(1'b0, 1'b0, '0);
        1:       set_config(1'b1, 1'b1, '1);
        2:       set_config(1'b0, 1'b1, seq_line);
        default: set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                            draw_compare());
      endcase
      tx_idle = (round != 3);
      rx_idle = (round != 4);
      repeat (20) send_tick(LCDMS_CYC_W'($urandom_range(0, 63)));
    end
  endtask

  // Run through vblank and the frame wrap once, mostly with long ticks
  task automatic test_frame_sweep();
    int start;
    drain_results();
    set_config(1'b1, 1'b1, VBLANK_LINE - 1'b1);
    tx_idle = 1'b1;
    rx_idle = 1'b1;
    start = frames_seen;
    while (frames_seen == start)
      send_tick(($urandom_range(0, 7) == 0) ? draw_tick()
                                            : 6'($urandom_range(58, 63)));
  endtask

  // Fill the pipeline behind a stalled receiver, then pause the sender
  task automatic test_backpressure();
    drain_results();
    tx_idle = 1'b0;
    rx_idle = 1'b1;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    repeat (24) send_tick(draw_tick());
    drain_results();
    tx_idle = 1'b1;
    repeat (24) send_tick(draw_tick());
  endtask

  // Random configurations and idling in chunks
  task automatic test_random_mix();
    for (int chunk = 0; chunk < 5; chunk++) begin
      drain_results();
      set_config(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), draw_compare());
      if ($urandom_range(0, 3) == 0)
        write_reg(REG_SPARE, LCDMS_CFG_DATA_W'($urandom_range(0, 255)));
      tx_idle = ($urandom_range(0, 3) != 0);
      rx_idle = ($urandom_range(0, 3) != 0);
      repeat (20) send_tick(draw_tick());
    end
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_line_compare();
    test_frame_sweep();
    test_backpressure();
    test_random_mix();
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_status_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
